>>> src/gdu_pkg.sv
// Shared types, constants and calendar tables for the Gregorian date unit.
package gdu_pkg;

	localparam int unsigned DAY_W    = 5;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned YEAR_W   = 14;
	localparam int unsigned SERIAL_W = 22;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
	localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
	localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
	localparam logic [DAY_W-1:0]   DAY_LEAP_FEB = 5'd29;

	// floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT for every 14-bit x
	localparam int unsigned DIV100_SHIFT = 19;
	localparam int unsigned DIV100_PW    = YEAR_W + 13;
	localparam logic [DIV100_PW-1:0] DIV100_MUL = 27'd5243;
	localparam int unsigned CENT_W = DIV100_PW - DIV100_SHIFT;

	localparam logic [SERIAL_W-1:0] DAYS_PER_YEAR = 22'd365;

	typedef struct packed {
		logic                valid;
		logic [DAY_W-1:0]    dim;
		logic [SERIAL_W-1:0] serial;
	} date_info_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = leap ? DAY_LEAP_FEB : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
		logic [8:0] d;
		case (m)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

>>> src/gdu_date_eval.sv
// Validity, month length and serial day number of one date.
module gdu_date_eval (
	input  logic [gdu_pkg::DAY_W-1:0]   day,
	input  logic [gdu_pkg::MONTH_W-1:0] month,
	input  logic [gdu_pkg::YEAR_W-1:0]  year,
	output gdu_pkg::date_info_t         info
);

	logic [gdu_pkg::YEAR_W-1:0]    prev_year;
	logic [gdu_pkg::DIV100_PW-1:0] prod_y;
	logic [gdu_pkg::DIV100_PW-1:0] prod_p;
	logic [gdu_pkg::CENT_W-1:0]    cent_y;
	logic [gdu_pkg::CENT_W-1:0]    cent_p;
	logic                          century;
	logic                          leap;
	logic [gdu_pkg::DAY_W-1:0]     dim;
	logic                          ok;
	logic [gdu_pkg::SERIAL_W-1:0]  prev_ext;
	logic [gdu_pkg::SERIAL_W-1:0]  cent_ext;
	logic [gdu_pkg::SERIAL_W-1:0]  serial;

	assign prev_year = year - gdu_pkg::YEAR_MIN;
	assign prod_y    = gdu_pkg::DIV100_PW'(year) * gdu_pkg::DIV100_MUL;
	assign prod_p    = gdu_pkg::DIV100_PW'(prev_year) * gdu_pkg::DIV100_MUL;
	assign cent_y    = prod_y[gdu_pkg::DIV100_PW-1:gdu_pkg::DIV100_SHIFT];
	assign cent_p    = prod_p[gdu_pkg::DIV100_PW-1:gdu_pkg::DIV100_SHIFT];

	// year is a multiple of 100 exactly when its century count steps over year - 1
	assign century = (cent_y != cent_p);
	assign leap    = (year[1:0] == 2'b00) && (!century || (cent_y[1:0] == 2'b00));
	assign dim     = gdu_pkg::month_len(month, leap);

	assign ok = (month >= gdu_pkg::MONTH_JAN) && (month <= gdu_pkg::MONTH_DEC) &&
		(year >= gdu_pkg::YEAR_MIN) && (year <= gdu_pkg::YEAR_MAX) &&
		(day != '0) && (day <= dim);

	assign prev_ext = gdu_pkg::SERIAL_W'(prev_year);
	assign cent_ext = gdu_pkg::SERIAL_W'(cent_p);

	assign serial = prev_ext * gdu_pkg::DAYS_PER_YEAR + (prev_ext >> 2) - cent_ext +
		(cent_ext >> 2) + gdu_pkg::SERIAL_W'(gdu_pkg::days_before(month)) +
		gdu_pkg::SERIAL_W'(leap && (month > gdu_pkg::MONTH_FEB)) +
		gdu_pkg::SERIAL_W'(day);

	assign info.valid  = ok;
	assign info.dim    = dim;
	assign info.serial = ok ? serial : '0;

endmodule

>>> src/gregorian_date_unit.sv
// Top level of the Gregorian date unit: input register, date logic, result register.
// A beat taken into the input register shows its result from the result register, done high one cycle.
// Throughput: one beat per cycle; busy stays low, so start may be held every cycle.
// The path from input register to result register is the constant-multiply serial sum
// of each date followed by the gap subtraction.
// Reset: arst_n clears the pipeline valid flags; no done pulse follows reset by itself.
module gregorian_date_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [gdu_pkg::DAY_W-1:0]      day_a,
	input  logic [gdu_pkg::MONTH_W-1:0]    month_a,
	input  logic [gdu_pkg::YEAR_W-1:0]     year_a,
	input  logic [gdu_pkg::DAY_W-1:0]      day_b,
	input  logic [gdu_pkg::MONTH_W-1:0]    month_b,
	input  logic [gdu_pkg::YEAR_W-1:0]     year_b,
	output logic                           done,
	output logic                           valid_a,
	output logic                           valid_b,
	output logic                           equal,
	output logic                           a_before_b,
	output logic [gdu_pkg::SERIAL_W-1:0]   serial_a,
	output logic [gdu_pkg::SERIAL_W-1:0]   serial_b,
	output logic [gdu_pkg::SERIAL_W-1:0]   day_gap,
	output logic [gdu_pkg::DAY_W-1:0]      next_day,
	output logic [gdu_pkg::MONTH_W-1:0]    next_month,
	output logic [gdu_pkg::YEAR_W-1:0]     next_year
);

	logic                        go_s1;
	logic [gdu_pkg::DAY_W-1:0]   day_a_s1;
	logic [gdu_pkg::MONTH_W-1:0] month_a_s1;
	logic [gdu_pkg::YEAR_W-1:0]  year_a_s1;
	logic [gdu_pkg::DAY_W-1:0]   day_b_s1;
	logic [gdu_pkg::MONTH_W-1:0] month_b_s1;
	logic [gdu_pkg::YEAR_W-1:0]  year_b_s1;

	gdu_pkg::date_info_t info_a;
	gdu_pkg::date_info_t info_b;

	logic                         both;
	logic                         same;
	logic                         earlier;
	logic [gdu_pkg::SERIAL_W-1:0] gap;
	logic [gdu_pkg::DAY_W-1:0]    nd;
	logic [gdu_pkg::MONTH_W-1:0]  nm;
	logic [gdu_pkg::YEAR_W-1:0]   ny;

	logic                         done_s2;
	logic                         valid_a_s2;
	logic                         valid_b_s2;
	logic                         equal_s2;
	logic                         before_s2;
	logic [gdu_pkg::SERIAL_W-1:0] serial_a_s2;
	logic [gdu_pkg::SERIAL_W-1:0] serial_b_s2;
	logic [gdu_pkg::SERIAL_W-1:0] gap_s2;
	logic [gdu_pkg::DAY_W-1:0]    nd_s2;
	logic [gdu_pkg::MONTH_W-1:0]  nm_s2;
	logic [gdu_pkg::YEAR_W-1:0]   ny_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1   <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			go_s1   <= start && !busy;
			done_s2 <= go_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			day_a_s1   <= day_a;
			month_a_s1 <= month_a;
			year_a_s1  <= year_a;
			day_b_s1   <= day_b;
			month_b_s1 <= month_b;
			year_b_s1  <= year_b;
		end
	end

	gdu_date_eval u_eval_a (
		.day   (day_a_s1),
		.month (month_a_s1),
		.year  (year_a_s1),
		.info  (info_a)
	);

	gdu_date_eval u_eval_b (
		.day   (day_b_s1),
		.month (month_b_s1),
		.year  (year_b_s1),
		.info  (info_b)
	);

	// valid dates order the same way by (year, month, day) as by serial
	assign both = info_a.valid && info_b.valid;
	assign same = (year_a_s1 == year_b_s1) && (month_a_s1 == month_b_s1) &&
		(day_a_s1 == day_b_s1);
	assign earlier = (year_a_s1 < year_b_s1) ||
		((year_a_s1 == year_b_s1) && (month_a_s1 < month_b_s1)) ||
		((year_a_s1 == year_b_s1) && (month_a_s1 == month_b_s1) && (day_a_s1 < day_b_s1));

	assign gap = (info_a.serial >= info_b.serial) ? (info_a.serial - info_b.serial) :
		(info_b.serial - info_a.serial);

	always_comb begin
		nd = day_a_s1;
		nm = month_a_s1;
		ny = year_a_s1;
		if (info_a.valid) begin
			if (day_a_s1 < info_a.dim) begin
				nd = day_a_s1 + gdu_pkg::DAY_FIRST;
			end else begin
				nd = gdu_pkg::DAY_FIRST;
				if (month_a_s1 == gdu_pkg::MONTH_DEC) begin
					nm = gdu_pkg::MONTH_JAN;
					ny = year_a_s1 + gdu_pkg::YEAR_MIN;
				end else begin
					nm = month_a_s1 + gdu_pkg::MONTH_JAN;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			valid_a_s2  <= info_a.valid;
			valid_b_s2  <= info_b.valid;
			equal_s2    <= both && same;
			before_s2   <= both && earlier;
			serial_a_s2 <= info_a.serial;
			serial_b_s2 <= info_b.serial;
			gap_s2      <= gap;
			nd_s2       <= nd;
			nm_s2       <= nm;
			ny_s2       <= ny;
		end
	end

	assign done       = done_s2;
	assign valid_a    = valid_a_s2;
	assign valid_b    = valid_b_s2;
	assign equal      = equal_s2;
	assign a_before_b = before_s2;
	assign serial_a   = serial_a_s2;
	assign serial_b   = serial_b_s2;
	assign day_gap    = gap_s2;
	assign next_day   = nd_s2;
	assign next_month = nm_s2;
	assign next_year  = ny_s2;

endmodule

>>> src/gdu_checker.sv
// Port-level checks for the Gregorian date unit and their bind.
module gdu_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic                         valid_a,
	input logic                         valid_b,
	input logic                         equal,
	input logic                         a_before_b,
	input logic [gdu_pkg::SERIAL_W-1:0] serial_a,
	input logic [gdu_pkg::SERIAL_W-1:0] serial_b,
	input logic [gdu_pkg::SERIAL_W-1:0] day_gap
);

	a_beat_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("accepted beat gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##2 !done)
		else $error("result without an accepted beat");

	a_equal_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done && equal |-> valid_a && valid_b && !a_before_b && (day_gap == '0) &&
		(serial_a == serial_b))
		else $error("equal dates with differing serials");

	a_before_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && a_before_b |-> valid_a && valid_b && (serial_a < serial_b) &&
		(day_gap == serial_b - serial_a))
		else $error("a_before_b inconsistent with serials");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !valid_a |-> (serial_a == '0) && (day_gap == serial_b))
		else $error("invalid date A with nonzero serial");

endmodule

bind gregorian_date_unit gdu_checker u_gdu_checker (.*);
